// ----- src/quintic_trajectory_evaluator_macros.svh -----
// Assertion macros shared by the quintic trajectory evaluator RTL.
// Each expects clk_i and rst_ni in scope of the module that uses it.
`ifndef QUINTIC_TRAJECTORY_EVALUATOR_MACROS_SVH
`define QUINTIC_TRAJECTORY_EVALUATOR_MACROS_SVH

// Plain property, checked at every edge out of reset.
`define QTE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define QTE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/qte_pkg.sv -----
// Shared types, constants and term helpers for the quintic trajectory evaluator.
// No dependencies; used by every module of the block.
package qte_pkg;

  localparam int unsigned TIME_W     = 32;  // Q16.16 time
  localparam int unsigned COEF_W     = 48;  // Q24.24 coefficients and results
  localparam int unsigned NUM_COEF   = 6;
  localparam int unsigned COEF_IDX_W = 3;
  localparam int unsigned NUM_CELLS  = 5;   // Horner steps after the leading coefficient
  localparam int unsigned NUM_LANES  = 3;   // position, velocity, acceleration
  localparam int unsigned FRAC_STEP  = 16;  // fraction bits gained per multiply by s
  localparam int unsigned LIMB_W     = 32;
  localparam int unsigned NUM_LIMBS  = 7;
  localparam int unsigned ACC_W      = NUM_LIMBS * LIMB_W;
  localparam int unsigned EXT_W      = (NUM_LIMBS + 1) * LIMB_W;
  localparam int unsigned FACTOR_W   = 5;   // derivative factors up to 20
  localparam int unsigned CFG_IDX_W  = 4;

  localparam int unsigned LANE_POS = 0;
  localparam int unsigned LANE_VEL = 1;
  localparam int unsigned LANE_ACC = 2;

  localparam logic signed [TIME_W-1:0] START_TIME_RST = TIME_W'(0);
  localparam logic signed [TIME_W-1:0] END_TIME_RST   = TIME_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEFF_0    = 4'd0,
    CFG_COEFF_1    = 4'd1,
    CFG_COEFF_2    = 4'd2,
    CFG_COEFF_3    = 4'd3,
    CFG_COEFF_4    = 4'd4,
    CFG_COEFF_5    = 4'd5,
    CFG_START_TIME = 4'd6,
    CFG_END_TIME   = 4'd7
  } cfg_reg_e;

  typedef logic [ACC_W-1:0]         acc_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [NUM_COEF-1:0]     coef_arr_t;
  typedef acc_t [NUM_LANES-1:0]     lane_acc_t;

  // Item as it moves down the cell chain: |s|, sign of s, one accumulator per lane.
  typedef struct packed {
    logic              neg;
    logic [TIME_W-1:0] mag;
    lane_acc_t         acc;
  } cell_data_t;

  // Horner addend of one lane in cell number cell_no (1..NUM_CELLS). Velocity and
  // acceleration start later in the chain so that all lanes finish together.
  function automatic acc_t cell_term(coef_arr_t c, int unsigned cell_no, int unsigned lane);
    int unsigned idx;
    int unsigned factor;
    int unsigned shift;
    acc_t        base;
    acc_t        r;
    idx    = 0;
    factor = 0;
    shift  = 0;
    r      = '0;
    case (lane)
      LANE_POS: begin
        idx    = NUM_CELLS - cell_no;
        factor = 1;
        shift  = FRAC_STEP * cell_no;
      end
      LANE_VEL: begin
        idx    = NUM_CELLS + 1 - cell_no;
        factor = idx;
        shift  = FRAC_STEP * (cell_no - 1);
      end
      default: begin
        if (cell_no >= 2) begin
          idx    = NUM_CELLS + 2 - cell_no;
          factor = idx * (idx - 1);
          shift  = FRAC_STEP * (cell_no - 2);
        end
      end
    endcase
    if (factor != 0) begin
      base = {{(ACC_W-COEF_W){c[idx[COEF_IDX_W-1:0]][COEF_W-1]}}, c[idx[COEF_IDX_W-1:0]]};
      for (int b = 0; b < FACTOR_W; b++) begin
        if (factor[b]) begin
          r = r + (base << b);
        end
      end
      r = r << shift;
    end
    return r;
  endfunction

endpackage

// ----- src/qte_clamp.sv -----
// Entry stage: clamps the query time and seeds the lane accumulators.
// Depends on qte_pkg.
module qte_clamp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  logic signed [qte_pkg::TIME_W-1:0]  query_time_i,
  input  logic signed [qte_pkg::TIME_W-1:0]  start_time_i,
  input  logic signed [qte_pkg::TIME_W-1:0]  end_time_i,
  input  qte_pkg::coef_t                     coef5_i,
  output logic                               valid_o,
  input  logic                               stall_i,
  output qte_pkg::cell_data_t                data_o
);

  logic                              valid_q;
  qte_pkg::cell_data_t               data_q, data_d;
  logic signed [qte_pkg::TIME_W-1:0] raised;
  logic signed [qte_pkg::TIME_W-1:0] s;

  // Raise to start first, then lower to end: inverted bounds give end_time.
  always_comb begin
    raised = (query_time_i < start_time_i) ? start_time_i : query_time_i;
    s      = (raised > end_time_i) ? end_time_i : raised;
    data_d = '0;
    data_d.neg = s[qte_pkg::TIME_W-1];
    data_d.mag = s[qte_pkg::TIME_W-1] ? qte_pkg::TIME_W'(~s + 1'b1) : s;
    data_d.acc[qte_pkg::LANE_POS] =
      {{(qte_pkg::ACC_W-qte_pkg::COEF_W){coef5_i[qte_pkg::COEF_W-1]}}, coef5_i};
  end

  assign stall_o = valid_q & stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- src/qte_cell.sv -----
// One Horner cell: acc = acc * s + term for all three lanes, in two stages.
// Stage 1 forms 32x32 limb products, stage 2 sums them with the addend.
// Depends on qte_pkg.
module qte_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  qte_pkg::cell_data_t  data_i,
  input  qte_pkg::lane_acc_t   term_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output qte_pkg::cell_data_t  data_o
);

  localparam int unsigned LW = qte_pkg::LIMB_W;

  logic [2*LW-1:0]           prod   [qte_pkg::NUM_LANES][qte_pkg::NUM_LIMBS];
  logic [qte_pkg::EXT_W-1:0] even_w [qte_pkg::NUM_LANES];
  logic [qte_pkg::EXT_W-1:0] odd_w  [qte_pkg::NUM_LANES];
  qte_pkg::lane_acc_t        even_q, odd_q;
  logic                      neg1_q;
  logic [qte_pkg::TIME_W-1:0] mag1_q;
  logic                      v1_q, v2_q;
  logic                      stall1, stall2;

  qte_pkg::acc_t             op_a  [qte_pkg::NUM_LANES];
  qte_pkg::acc_t             op_b  [qte_pkg::NUM_LANES];
  qte_pkg::acc_t             csa_s [qte_pkg::NUM_LANES];
  qte_pkg::acc_t             csa_c [qte_pkg::NUM_LANES];
  qte_pkg::cell_data_t       data2_d, data2_q;

  // Even limb products do not overlap each other, nor do odd ones, so each
  // group packs into one word and the partial sum is even + odd mod 2^ACC_W.
  always_comb begin
    for (int l = 0; l < qte_pkg::NUM_LANES; l++) begin
      even_w[l] = '0;
      odd_w[l]  = '0;
      for (int i = 0; i < qte_pkg::NUM_LIMBS; i++) begin
        prod[l][i] = (2*LW)'(data_i.acc[l][i*LW +: LW]) * (2*LW)'(data_i.mag);
      end
      for (int i = 0; i < qte_pkg::NUM_LIMBS; i += 2) begin
        even_w[l][i*LW +: 2*LW] = prod[l][i];
      end
      for (int i = 1; i < qte_pkg::NUM_LIMBS; i += 2) begin
        odd_w[l][i*LW +: 2*LW] = prod[l][i];
      end
    end
  end

  assign stall2  = v2_q & stall_i;
  assign stall1  = v1_q & stall2;
  assign stall_o = stall1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (!stall1) begin
        v1_q <= valid_i;
      end
      if (!stall2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall1 && valid_i) begin
      for (int l = 0; l < qte_pkg::NUM_LANES; l++) begin
        even_q[l] <= even_w[l][qte_pkg::ACC_W-1:0];
        odd_q[l]  <= odd_w[l][qte_pkg::ACC_W-1:0];
      end
      neg1_q <= data_i.neg;
      mag1_q <= data_i.mag;
    end
  end

  // Negative s: -(even + odd) + term = ~even + ~odd + term + 2, one 3:2 row
  // and a single carry-propagate add.
  always_comb begin
    data2_d     = '0;
    data2_d.neg = neg1_q;
    data2_d.mag = mag1_q;
    for (int l = 0; l < qte_pkg::NUM_LANES; l++) begin
      op_a[l]  = even_q[l] ^ {qte_pkg::ACC_W{neg1_q}};
      op_b[l]  = odd_q[l] ^ {qte_pkg::ACC_W{neg1_q}};
      csa_s[l] = op_a[l] ^ op_b[l] ^ term_i[l];
      csa_c[l] = (op_a[l] & op_b[l]) | (op_a[l] & term_i[l]) | (op_b[l] & term_i[l]);
      data2_d.acc[l] = csa_s[l] + {csa_c[l][qte_pkg::ACC_W-2:0], neg1_q}
                       + qte_pkg::ACC_W'(neg1_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall2 && v1_q) begin
      data2_q <= data2_d;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = data2_q;

endmodule

// ----- src/qte_round.sv -----
// Exit stage: rounds each lane to Q24.24 (ties up), saturates to 48 bits and
// holds the result request. Depends on qte_pkg.
module qte_round (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  qte_pkg::cell_data_t                data_i,
  output logic                               valid_o,
  input  logic                               stall_i,
  output logic signed [qte_pkg::COEF_W-1:0]  position_o,
  output logic signed [qte_pkg::COEF_W-1:0]  velocity_o,
  output logic signed [qte_pkg::COEF_W-1:0]  acceleration_o
);

  localparam int unsigned CW = qte_pkg::COEF_W;

  logic [CW-1:0] res_d [qte_pkg::NUM_LANES];
  logic [CW-1:0] res_q [qte_pkg::NUM_LANES];
  logic          valid_q;

  for (genvar l = 0; l < qte_pkg::NUM_LANES; l++) begin : g_lane
    // Lane l carries (NUM_CELLS - l) * 16 extra fraction bits.
    localparam int unsigned SH = qte_pkg::FRAC_STEP * (qte_pkg::NUM_CELLS - l);
    localparam int unsigned HW = qte_pkg::ACC_W - SH;

    qte_pkg::acc_t   biased;
    logic [HW-1:0]   hi;
    logic            fits;

    assign biased = data_i.acc[l] + (qte_pkg::ACC_W'(1) << (SH - 1));
    assign hi     = biased[qte_pkg::ACC_W-1:SH];
    assign fits   = (&hi[HW-1:CW-1]) | ~(|hi[HW-1:CW-1]);
    assign res_d[l] = fits ? hi[CW-1:0]
                    : (hi[HW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}});
  end

  assign stall_o = valid_q & stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o        = valid_q;
  assign position_o     = res_q[qte_pkg::LANE_POS];
  assign velocity_o     = res_q[qte_pkg::LANE_VEL];
  assign acceleration_o = res_q[qte_pkg::LANE_ACC];

endmodule

// ----- src/quintic_trajectory_evaluator.sv -----
// Quintic trajectory evaluator: each request carries a Q16.16 query time,
// which is clamped to [start_time, end_time] (end_time wins when the bounds
// are inverted); the result request gives position, velocity and
// acceleration of the loaded quintic at that time, Q24.24, rounded to
// nearest with ties up and saturated to 48 bits. One request is taken per
// cycle unless in_stall_o is high; results leave in order after one clamp
// stage, five Horner cells of two stages each (a bank of 32x32 limb
// multipliers, then a carry-save add of the coefficient term) and one
// rounding stage. Stalls fill bubbles, so requests keep entering while a
// result waits, until bubbles run out. The cells see coefficient writes
// via term_q; write configuration only while no request is in flight.
`include "quintic_trajectory_evaluator_macros.svh"

module quintic_trajectory_evaluator (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [qte_pkg::TIME_W-1:0]     query_time_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [qte_pkg::COEF_W-1:0]     position_o,
  output logic signed [qte_pkg::COEF_W-1:0]     velocity_o,
  output logic signed [qte_pkg::COEF_W-1:0]     acceleration_o,
  input  logic                                  cfg_we_i,
  input  logic [qte_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [qte_pkg::COEF_W-1:0]            cfg_data_i
);

  qte_pkg::coef_arr_t                coef_q;
  logic signed [qte_pkg::TIME_W-1:0] start_time_q;
  logic signed [qte_pkg::TIME_W-1:0] end_time_q;

  qte_pkg::lane_acc_t  term_d [qte_pkg::NUM_CELLS];
  qte_pkg::lane_acc_t  term_q [qte_pkg::NUM_CELLS];

  logic [qte_pkg::NUM_CELLS:0] link_valid;
  logic [qte_pkg::NUM_CELLS:0] link_stall;
  qte_pkg::cell_data_t         link_data [qte_pkg::NUM_CELLS+1];

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q       <= '0;
      start_time_q <= qte_pkg::START_TIME_RST;
      end_time_q   <= qte_pkg::END_TIME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i) inside
        qte_pkg::CFG_COEFF_0, qte_pkg::CFG_COEFF_1, qte_pkg::CFG_COEFF_2,
        qte_pkg::CFG_COEFF_3, qte_pkg::CFG_COEFF_4, qte_pkg::CFG_COEFF_5: begin
          coef_q[cfg_idx_i[qte_pkg::COEF_IDX_W-1:0]] <= cfg_data_i;
        end
        qte_pkg::CFG_START_TIME: begin
          start_time_q <= cfg_data_i[qte_pkg::TIME_W-1:0];
        end
        qte_pkg::CFG_END_TIME: begin
          end_time_q <= cfg_data_i[qte_pkg::TIME_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Per-cell addends: scaled, derivative-weighted coefficients.
  for (genvar c = 0; c < qte_pkg::NUM_CELLS; c++) begin : g_term
    for (genvar l = 0; l < qte_pkg::NUM_LANES; l++) begin : g_lane
      assign term_d[c][l] = qte_pkg::cell_term(coef_q, c + 1, l);
    end
    always_ff @(posedge clk_i) begin
      term_q[c] <= term_d[c];
    end
  end

  qte_clamp u_clamp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_i),
    .stall_o      (in_stall_o),
    .query_time_i (query_time_i),
    .start_time_i (start_time_q),
    .end_time_i   (end_time_q),
    .coef5_i      (coef_q[qte_pkg::NUM_COEF-1]),
    .valid_o      (link_valid[0]),
    .stall_i      (link_stall[0]),
    .data_o       (link_data[0])
  );

  for (genvar c = 0; c < qte_pkg::NUM_CELLS; c++) begin : g_cell
    qte_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (link_valid[c]),
      .stall_o (link_stall[c]),
      .data_i  (link_data[c]),
      .term_i  (term_q[c]),
      .valid_o (link_valid[c+1]),
      .stall_i (link_stall[c+1]),
      .data_o  (link_data[c+1])
    );
  end

  qte_round u_round (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (link_valid[qte_pkg::NUM_CELLS]),
    .stall_o        (link_stall[qte_pkg::NUM_CELLS]),
    .data_i         (link_data[qte_pkg::NUM_CELLS]),
    .valid_o        (out_valid_o),
    .stall_i        (out_stall_i),
    .position_o     (position_o),
    .velocity_o     (velocity_o),
    .acceleration_o (acceleration_o)
  );

  // Backpressure only ever originates at the result side.
  `QTE_ASSERT_IMPL(a_stall_source, in_stall_o, out_valid_o && out_stall_i, "input stalled without a held result")
  `QTE_ASSERT_NEXT(a_cfg_unknown, cfg_we_i && (cfg_idx_i > qte_pkg::CFG_END_TIME), $stable(coef_q) && $stable(start_time_q) && $stable(end_time_q), "write to unknown index changed configuration")
  `QTE_ASSERT_NEXT(a_cfg_end, cfg_we_i && (cfg_idx_i == qte_pkg::CFG_END_TIME), end_time_q == $past(cfg_data_i[qte_pkg::TIME_W-1:0]), "end time write lost")

endmodule

// ----- sim/quintic_trajectory_evaluator_tb.sv -----
// Self-checking testbench for quintic_trajectory_evaluator: clamped quintic position,
// velocity and acceleration checked against an exact wide-integer predictor.
// Depends on qte_pkg and the evaluator RTL only.
module quintic_trajectory_evaluator_tb;
  import qte_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 8;
  localparam int IDLE_PCT     = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int STUCK_LIMIT  = 4 * HOLD_CYCLES;
  localparam int TAIL_CYCLES  = 40;
  localparam int MAX_REPORTS  = 10;
  localparam int DEGREE       = NUM_COEF - 1;
  localparam int EXACT_W      = 256;
  localparam int SPARE_IDX_FIRST = CFG_END_TIME + 1;
  localparam int SPARE_IDX_LAST  = (1 << CFG_IDX_W) - 1;

  typedef logic signed [TIME_W-1:0]  qtime_t;
  typedef logic signed [EXACT_W-1:0] exact_t;

  localparam coef_t  COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t  COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam qtime_t TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
  localparam qtime_t TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

  typedef struct packed {
    qtime_t query;
    coef_t  position;
    coef_t  velocity;
    coef_t  acceleration;
  } motion_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  qtime_t                query_time_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  coef_t                 position_o;
  coef_t                 velocity_o;
  coef_t                 acceleration_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [COEF_W-1:0]     cfg_data_i;

  // register shadow used by the predictor
  coef_t   coeffs_q [NUM_COEF];
  qtime_t  start_q;
  qtime_t  end_q;

  // next profile to load
  coef_t   profile_coef [NUM_COEF];
  qtime_t  profile_start;
  qtime_t  profile_end;

  motion_t pending_motion [$];
  motion_t due;

  logic idle_on = 1'b1;
  int   hold_asked = 0;
  int   hold_served = 0;
  int   hold_left = 0;
  int   stuck_cycles = 0;
  int   error_count = 0;
  int   reported_count = 0;
  int   queries_sent = 0;
  int   results_checked = 0;
  int   profiles_loaded = 0;

  quintic_trajectory_evaluator uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .query_time_i   (query_time_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .position_o     (position_o),
    .velocity_o     (velocity_o),
    .acceleration_o (acceleration_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // Exact Horner sum scaled by 2^(16*(DEGREE-order)) extra fraction bits, then
  // round half up and saturate to Q24.24.
  function automatic coef_t eval_derivative(int order, qtime_t s);
    exact_t sum;
    exact_t term;
    exact_t s_w;
    exact_t half;
    exact_t hi_lim;
    exact_t lo_lim;
    int     factor;
    int     shift;
    sum    = '0;
    s_w    = s;
    hi_lim = COEF_MAX;
    lo_lim = COEF_MIN;
    shift  = FRAC_STEP * (DEGREE - order);
    for (int k = DEGREE; k >= order; k--) begin
      case (order)
        LANE_POS: factor = 1;
        LANE_VEL: factor = k;
        default:  factor = k * (k - 1);
      endcase
      term = coeffs_q[k];
      term = term * factor;
      sum  = sum * s_w + (term <<< (FRAC_STEP * (DEGREE - k)));
    end
    half = 1;
    half = half <<< (shift - 1);
    sum  = (sum + half) >>> shift;
    if (sum > hi_lim) return COEF_MAX;
    if (sum < lo_lim) return COEF_MIN;
    return sum[COEF_W-1:0];
  endfunction

  function automatic motion_t predict_motion(qtime_t q);
    motion_t m;
    qtime_t  s;
    s = q;
    // raise to start first, then lower to end: end wins when bounds are inverted
    if (s < start_q) s = start_q;
    if (s > end_q) s = end_q;
    m.query        = q;
    m.position     = eval_derivative(LANE_POS, s);
    m.velocity     = eval_derivative(LANE_VEL, s);
    m.acceleration = eval_derivative(LANE_ACC, s);
    return m;
  endfunction

  function automatic coef_t rand_coef();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(15))
      0, 1:    return '0;
      2:       return COEF_MAX;
      3:       return COEF_MIN;
      4, 5:    return coef_t'(r);
      default: return coef_t'($signed(r) >>> $urandom_range(62, 16));
    endcase
  endfunction

  function automatic qtime_t pick_query();
    qtime_t off;
    off = qtime_t'($signed($urandom) >>> $urandom_range(31, 8));
    case ($urandom_range(3))
      0:       return qtime_t'($urandom);
      1:       return start_q + off;
      2:       return end_q + off;
      default: return start_q + ((end_q - start_q) >>> 1) + off;
    endcase
  endfunction

  task automatic note_mismatch(input string field, input qtime_t q, input coef_t want,
                               input coef_t got);
    error_count++;
    if (reported_count < MAX_REPORTS) begin
      reported_count++;
      $display("%0t: %s mismatch for query %h: expected %h, got %h",
               $realtime, field, q, want, got);
    end
  endtask

  // write enable is left high so back-to-back writes never toggle it within one step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx <= CFG_COEFF_5) coeffs_q[idx] = coef_t'(data);
    else if (idx == CFG_START_TIME) start_q = data[TIME_W-1:0];
    else if (idx == CFG_END_TIME) end_q = data[TIME_W-1:0];
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_motion.size() != 0) @(posedge clk_i);
  endtask

  task automatic apply_profile();
    drain_results();
    if ($urandom_range(3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(SPARE_IDX_LAST, SPARE_IDX_FIRST)),
                COEF_W'({$urandom, $urandom}));
    for (int k = 0; k < NUM_COEF; k++)
      write_reg(CFG_IDX_W'(CFG_COEFF_0 + k), profile_coef[k]);
    // upper data bits are junk for the time registers
    write_reg(CFG_START_TIME, {(COEF_W-TIME_W)'($urandom), profile_start});
    write_reg(CFG_END_TIME, {(COEF_W-TIME_W)'($urandom), profile_end});
    cfg_we_i <= 1'b0;
    profiles_loaded++;
  endtask

  task automatic randomize_profile();
    qtime_t tmp;
    for (int k = 0; k < NUM_COEF; k++) profile_coef[k] = rand_coef();
    profile_start = qtime_t'($signed($urandom) >>> $urandom_range(31, 12));
    profile_end   = profile_start + qtime_t'($urandom >> $urandom_range(31, 12));
    case ($urandom_range(7))
      0: begin
        tmp           = profile_start;
        profile_start = profile_end;
        profile_end   = tmp;
      end
      1: begin
        profile_start = TIME_MIN;
        profile_end   = TIME_MAX;
      end
      2: profile_end = profile_start;
      default: ;
    endcase
  endtask

  // valid stays high on return; the next call or a drain decides what it does next
  task automatic send_query(input qtime_t q);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    query_time_i <= q;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_motion.push_back(predict_motion(q));
    queries_sent++;
  endtask

  task automatic test_reset_state();
    send_query('0);
    send_query(TIME_MAX);
    send_query(TIME_MIN);
  endtask

  task automatic test_extremes();
    for (int k = 0; k < NUM_COEF; k++) profile_coef[k] = COEF_MAX;
    profile_start = TIME_MIN;
    profile_end   = TIME_MAX;
    apply_profile();
    send_query(TIME_MAX);
    send_query(TIME_MIN);
    send_query('0);
    send_query(32'sd1);
    send_query(-32'sd1);
    for (int k = 0; k < NUM_COEF; k++) profile_coef[k] = COEF_MIN;
    apply_profile();
    send_query(TIME_MAX);
    send_query(TIME_MIN);
  endtask

  // one-LSB linear and quadratic terms put results on exact half steps
  task automatic test_rounding_ties();
    for (int k = 0; k < NUM_COEF; k++) profile_coef[k] = '0;
    profile_coef[CFG_COEFF_1] = 1;
    profile_coef[CFG_COEFF_2] = 1;
    profile_start = -32'sh0002_0000;
    profile_end   = 32'sh0002_0000;
    apply_profile();
    send_query(32'sh0000_8000);
    send_query(-32'sh0000_8000);
    send_query(32'sh0000_4000);
    send_query(-32'sh0000_4000);
    send_query(-32'sh0000_C000);
    send_query(TIME_MAX);
    send_query(TIME_MIN);
  endtask

  task automatic test_inverted_bounds();
    for (int k = 0; k < NUM_COEF; k++) profile_coef[k] = '0;
    profile_coef[CFG_COEFF_3] = 48'sh0000_0100_0000;
    profile_coef[CFG_COEFF_5] = -48'sh0000_0100_0000;
    profile_start = 32'sh0002_0000;
    profile_end   = 32'sh0001_0000;
    apply_profile();
    send_query('0);
    send_query(32'sh0003_0000);
    send_query(32'sh0001_8000);
  endtask

  task automatic test_spare_index_writes();
    drain_results();
    for (int i = SPARE_IDX_FIRST; i <= SPARE_IDX_LAST; i++)
      write_reg(CFG_IDX_W'(i), {COEF_W{1'b1}});
    cfg_we_i <= 1'b0;
    send_query('0);
    send_query(TIME_MAX);
  endtask

  task automatic test_random_profiles();
    for (int p = 0; p < 12; p++) begin
      randomize_profile();
      apply_profile();
      repeat (90) send_query(pick_query());
    end
  endtask

  task automatic test_output_backpressure();
    randomize_profile();
    apply_profile();
    hold_asked++;
    repeat (80) send_query(pick_query());
    drain_results();
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    randomize_profile();
    apply_profile();
    repeat (300) send_query(pick_query());
    drain_results();
    idle_on = 1'b1;
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_motion.size() == 0) begin
        error_count++;
        if (reported_count < MAX_REPORTS) begin
          reported_count++;
          $display("%0t: result with nothing outstanding: %h %h %h",
                   $realtime, position_o, velocity_o, acceleration_o);
        end
      end else begin
        due = pending_motion.pop_front();
        results_checked++;
        if (position_o !== due.position)
          note_mismatch("position", due.query, due.position, position_o);
        if (velocity_o !== due.velocity)
          note_mismatch("velocity", due.query, due.velocity, velocity_o);
        if (acceleration_o !== due.acceleration)
          note_mismatch("acceleration", due.query, due.acceleration, acceleration_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("quintic_trajectory_evaluator_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    query_time_i = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_COEFF_0;
    cfg_data_i   = '0;
    for (int k = 0; k < NUM_COEF; k++) coeffs_q[k] = '0;
    start_q = START_TIME_RST;
    end_q   = END_TIME_RST;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_extremes();
    test_rounding_ties();
    test_inverted_bounds();
    test_spare_index_writes();
    test_random_profiles();
    test_output_backpressure();
    test_back_to_back();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Checked %0d results of %0d queries over %0d register profiles,",
             results_checked, queries_sent, profiles_loaded);
    $display("with saturation, half-step ties, inverted bounds, spare writes and hold-off.");
    if (error_count == 0)
      $display("quintic_trajectory_evaluator_tb: PASS");
    else
      $display("quintic_trajectory_evaluator_tb: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/qte_pkg.sv
src/qte_clamp.sv
src/qte_cell.sv
src/qte_round.sv
src/quintic_trajectory_evaluator.sv
sim/quintic_trajectory_evaluator_tb.sv
